FILE: src/sync_frame_receiver_crc16_defines.svh
// Assertion macros for the sync frame receiver.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef SYNC_FRAME_RECEIVER_CRC16_DEFINES_SVH
`define SYNC_FRAME_RECEIVER_CRC16_DEFINES_SVH

`ifndef SYNTHESIS
`define SFR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfr check failed");
`define SFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfr check failed");
`else
`define SFR_ASSERT_SAME(label, ante, cons)
`define SFR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: src/sfr_pkg.sv
`timescale 1ns / 1ps
package sfr_pkg;

    localparam logic [7:0]  SYNC_FIRST    = 8'h4D;  // 'M'
    localparam logic [7:0]  SYNC_SECOND   = 8'h43;  // 'C'
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL = 16'h8408;  // 0x1021 reflected
    localparam logic [15:0] CRC_RESIDUE   = 16'hF0B8;
    localparam logic [8:0]  HEADER_LEN    = 9'd4;
    localparam logic [7:0]  MIN_LENGTH    = 8'd6;

    localparam logic [2:0] ST_STATUS_OK  = 3'd0;
    localparam logic [2:0] ST_ENCODER_OK = 3'd1;
    localparam logic [2:0] ST_BAD_CRC    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN    = 3'd3;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd4;

    localparam logic CFG_STATUS_TYPE  = 1'b0;
    localparam logic CFG_ENCODER_TYPE = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT_FIRST  = 3'd0,
        PH_HUNT_SECOND = 3'd1,
        PH_TYPE        = 3'd2,
        PH_LENGTH      = 3'd3,
        PH_PAYLOAD     = 3'd4
    } t_phase;

    // One byte through the reflected CRC, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Register value after the two sync bytes.
    localparam logic [15:0] CRC_AFTER_SYNC = crc_byte(crc_byte(CRC_INIT, SYNC_FIRST), SYNC_SECOND);

endpackage

FILE: src/sync_frame_receiver_crc16.sv
`timescale 1ns / 1ps
// Latency: a result appears on o_valid in the cycle after the byte that causes it.
// Throughput: one byte per cycle while o_stall is low; the byte-wide CRC update
//   and the phase logic sit between the input port and the result register.
// Reset (i_rst_n low, synchronous): hunting for 'M', CRC = 0xFFFF, no result held,
//   frame types back to status 1 and encoder 2.
`include "sync_frame_receiver_crc16_defines.svh"

module sync_frame_receiver_crc16
    import sfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_byte_index,
    output logic [7:0] o_frame_kind,
    output logic       o_frame_last,
    output logic [2:0] o_frame_status,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers: always ready. They are to be written only while idle; the block does not enforce this.
    // ---------------------------------------------------------------
    logic [7:0] r_status_type;
    logic [7:0] r_encoder_type;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status_type  <= 8'd1;
            r_encoder_type <= 8'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_STATUS_TYPE:  r_status_type  <= i_cfg_data;
                CFG_ENCODER_TYPE: r_encoder_type <= i_cfg_data;
                default:          r_status_type  <= r_status_type;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Frame state
    // ---------------------------------------------------------------
    t_phase      r_phase, n_phase;
    logic [7:0]  r_held_type, n_held_type;
    logic [7:0]  r_held_length, n_held_length;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_crc, n_crc;

    // Result register (output stage)
    logic       r_out_valid;
    logic [7:0] r_out_payload;
    logic [7:0] r_out_index;
    logic [7:0] r_out_kind;
    logic       r_out_last;
    logic [2:0] r_out_status;

    // Result for the byte at the input
    logic       n_res_valid;
    logic [7:0] n_res_payload;
    logic [7:0] n_res_index;
    logic       n_res_last;
    logic [2:0] n_res_status;

    logic in_acc;
    // The output stage frees up in the same cycle it is taken, so a byte can
    // follow every cycle unless the downstream side holds a pending result.
    assign o_stall = r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;

    // Shared datapath terms
    logic [15:0] crc_next;
    logic [8:0]  count_inc;
    logic [8:0]  payload_total;
    logic        is_last;
    logic [2:0]  end_status;

    assign crc_next      = crc_byte(r_crc, i_rx_byte);
    assign count_inc     = {1'b0, r_count} + 9'd1;
    assign payload_total = {1'b0, r_held_length} - HEADER_LEN;  // length >= 6 here
    assign is_last       = (count_inc >= payload_total);

    // End-of-frame status: CRC first, then the type match (status type wins).
    always_comb begin
        priority if (crc_next != CRC_RESIDUE) begin
            end_status = ST_BAD_CRC;
        end else if (r_held_type == r_status_type) begin
            end_status = ST_STATUS_OK;
        end else if (r_held_type == r_encoder_type) begin
            end_status = ST_ENCODER_OK;
        end else begin
            end_status = ST_UNKNOWN;
        end
    end

    // Next phase
    always_comb begin
        unique case (r_phase)
            PH_HUNT_FIRST:  n_phase = (i_rx_byte == SYNC_FIRST) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
            // a broken second sync byte is not retried as 'M'
            PH_HUNT_SECOND: n_phase = (i_rx_byte == SYNC_SECOND) ? PH_TYPE : PH_HUNT_FIRST;
            PH_TYPE:        n_phase = PH_LENGTH;
            PH_LENGTH:      n_phase = (i_rx_byte < MIN_LENGTH) ? PH_HUNT_FIRST : PH_PAYLOAD;
            PH_PAYLOAD:     n_phase = is_last ? PH_HUNT_FIRST : PH_PAYLOAD;
            default:        n_phase = (i_rx_byte == SYNC_FIRST) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
        endcase
    end

    // Datapath and result
    always_comb begin
        n_held_type   = r_held_type;
        n_held_length = r_held_length;
        n_count       = r_count;
        n_crc         = r_crc;
        n_res_valid   = 1'b0;
        n_res_payload = i_rx_byte;
        n_res_index   = r_count;
        n_res_last    = 1'b0;
        n_res_status  = ST_STATUS_OK;
        unique case (r_phase)
            PH_HUNT_SECOND: begin
                if (i_rx_byte == SYNC_SECOND) begin
                    n_crc = CRC_AFTER_SYNC;
                end
            end
            PH_TYPE: begin
                n_held_type = i_rx_byte;
                n_crc       = crc_next;
            end
            PH_LENGTH: begin
                n_held_length = i_rx_byte;
                n_crc         = crc_next;
                n_count       = 8'd0;
                if (i_rx_byte < MIN_LENGTH) begin
                    // short length: single terminating result
                    n_res_valid   = 1'b1;
                    n_res_payload = 8'd0;
                    n_res_index   = 8'd0;
                    n_res_last    = 1'b1;
                    n_res_status  = ST_BAD_LENGTH;
                end
            end
            PH_PAYLOAD: begin
                n_crc       = crc_next;
                n_count     = count_inc[7:0];
                n_res_valid = 1'b1;
                if (is_last) begin
                    n_res_last   = 1'b1;
                    n_res_status = end_status;
                end
            end
            default: begin
                n_crc = r_crc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT_FIRST;
            r_held_type   <= 8'd0;
            r_held_length <= 8'd0;
            r_count       <= 8'd0;
            r_crc         <= CRC_INIT;
        end else if (in_acc) begin
            r_phase       <= n_phase;
            r_held_type   <= n_held_type;
            r_held_length <= n_held_length;
            r_count       <= n_count;
            r_crc         <= n_crc;
        end
    end

    // Output stage: loaded on an accepted byte that yields a result,
    // emptied when the transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= n_res_valid;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_res_valid) begin
            r_out_payload <= n_res_payload;
            r_out_index   <= n_res_index;
            r_out_kind    <= r_held_type;
            r_out_last    <= n_res_last;
            r_out_status  <= n_res_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_payload_byte = r_out_payload;
    assign o_byte_index   = r_out_index;
    assign o_frame_kind   = r_out_kind;
    assign o_frame_last   = r_out_last;
    assign o_frame_status = r_out_status;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `SFR_ASSERT_SAME(a_mid_frame_status_ok, o_valid && !o_frame_last, o_frame_status == ST_STATUS_OK)
    `SFR_ASSERT_SAME(a_bad_len_shape, o_valid && o_frame_status == ST_BAD_LENGTH, o_frame_last && o_payload_byte == 8'd0)
    `SFR_ASSERT_SAME(a_payload_len_ok, r_phase == PH_PAYLOAD, r_held_length >= MIN_LENGTH)
    `SFR_ASSERT_NEXT(a_last_rehunts, in_acc && n_res_valid && n_res_last, r_phase == PH_HUNT_FIRST)

endmodule

FILE: sim/sync_frame_receiver_crc16_tb.sv
`timescale 1ns / 1ps
module sync_frame_receiver_crc16_tb;
    import sfr_pkg::*;

    localparam int NUM_PHASES   = 8;
    localparam int PHASE_BYTES  = 195;  // framed bytes per config phase
    localparam int DRAIN_CYCLES = 4;    // margin after the registered result output
    localparam int MAX_REPORTS  = 10;

    // One byte transaction on the input channel plus the idle cycles that follow it.
    typedef struct {
        logic [7:0]  data;
        int unsigned gap;
    } t_rx_item;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_kind;
        logic       frame_last;
        logic [2:0] frame_status;
    } t_frame_result;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic       o_stall;
    logic [7:0] i_rx_byte      = 8'h00;
    logic       o_valid;
    logic       i_stall        = 1'b0;
    logic [7:0] o_payload_byte;
    logic [7:0] o_byte_index;
    logic [7:0] o_frame_kind;
    logic       o_frame_last;
    logic [2:0] o_frame_status;
    logic       i_cfg_valid    = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_index    = CFG_STATUS_TYPE;
    logic [7:0] i_cfg_data     = 8'h00;

    // Bytes waiting for the driver, and results the deframer model says must come out.
    t_rx_item      rx_queue[$];
    t_frame_result expected_results[$];

    // Deframer model state and its copy of the frame type registers.
    t_phase      rx_phase;
    logic [7:0]  held_kind;
    logic [7:0]  held_len;
    logic [7:0]  payload_count;
    logic [15:0] rx_crc;
    logic [7:0]  exp_status_type;
    logic [7:0]  exp_encoder_type;

    int unsigned   gap_left;
    int unsigned   stall_left;
    int unsigned   error_count = 0;
    bit            rx_quiet     = 1'b0;  // result side never stalls
    bit            sender_burst = 1'b0;  // byte side sends back to back
    t_rx_item      next_item;
    t_frame_result seen_result;
    t_frame_result want_result;

    sync_frame_receiver_crc16 uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_kind   (o_frame_kind),
        .o_frame_last   (o_frame_last),
        .o_frame_status (o_frame_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Reflected CRC-16, one bit at a time, LSB first.
    function automatic logic [15:0] crc16_x25_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ b[k];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY_REFL;
            end
        end
        return c;
    endfunction

    function automatic void expect_result(input t_frame_result r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    task automatic reset_model();
        rx_phase         = PH_HUNT_FIRST;
        held_kind        = 8'h00;
        held_len         = 8'h00;
        payload_count    = 8'h00;
        rx_crc           = CRC_INIT;
        exp_status_type  = 8'd1;
        exp_encoder_type = 8'd2;
    endtask

    // Advance the deframer model by one accepted byte; queue the result it causes, if any.
    task automatic deframe_byte(input logic [7:0] b);
        logic [8:0] total;
        logic [2:0] status;
        case (rx_phase)
            PH_HUNT_SECOND: begin
                // A failed second sync byte is not rechecked as 'M'.
                if (b == SYNC_SECOND) begin
                    rx_crc   = crc16_x25_step(crc16_x25_step(CRC_INIT, SYNC_FIRST), SYNC_SECOND);
                    rx_phase = PH_TYPE;
                end else begin
                    rx_phase = PH_HUNT_FIRST;
                end
            end
            PH_TYPE: begin
                held_kind = b;
                rx_crc    = crc16_x25_step(rx_crc, b);
                rx_phase  = PH_LENGTH;
            end
            PH_LENGTH: begin
                held_len      = b;
                rx_crc        = crc16_x25_step(rx_crc, b);
                payload_count = 8'h00;
                if (b < MIN_LENGTH) begin
                    expect_result({8'h00, 8'h00, held_kind, 1'b1, ST_BAD_LENGTH});
                    rx_phase = PH_HUNT_FIRST;
                end else begin
                    rx_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                total  = {1'b0, held_len} - HEADER_LEN;
                rx_crc = crc16_x25_step(rx_crc, b);
                if ({1'b0, payload_count} + 9'd1 >= total) begin
                    if (rx_crc != CRC_RESIDUE) begin
                        status = ST_BAD_CRC;
                    end else if (held_kind == exp_status_type) begin
                        status = ST_STATUS_OK;
                    end else if (held_kind == exp_encoder_type) begin
                        status = ST_ENCODER_OK;
                    end else begin
                        status = ST_UNKNOWN;
                    end
                    expect_result({b, payload_count, held_kind, 1'b1, status});
                    rx_phase = PH_HUNT_FIRST;
                end else begin
                    expect_result({b, payload_count, held_kind, 1'b0, ST_STATUS_OK});
                end
                payload_count = payload_count + 8'd1;
            end
            default: begin
                if (b == SYNC_FIRST) begin
                    rx_phase = PH_HUNT_SECOND;
                end else begin
                    rx_phase = PH_HUNT_FIRST;
                end
            end
        endcase
    endtask

    task automatic log_mismatch(input string what, input t_frame_result want,
                                input t_frame_result got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%s at %0t: expected byte %h index %0d kind %h last %b status %0d",
                     what, $realtime, want.payload_byte, want.byte_index, want.frame_kind,
                     want.frame_last, want.frame_status);
            $display("    got byte %h index %0d kind %h last %b status %0d",
                     got.payload_byte, got.byte_index, got.frame_kind, got.frame_last,
                     got.frame_status);
        end
    endtask

    // Byte driver: one transaction per queue entry, then that entry's idle gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else if (!i_valid || !o_stall) begin
            if (gap_left != 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (rx_queue.size() != 0) begin
                next_item = rx_queue.pop_front();
                i_rx_byte <= next_item.data;
                i_valid   <= 1'b1;
                gap_left  = next_item.gap;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks result transactions against the model, stalls the result side
    // at random, and feeds every accepted byte to the model.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            stall_left = 0;
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                seen_result = {o_payload_byte, o_byte_index, o_frame_kind, o_frame_last,
                               o_frame_status};
                if (expected_results.size() == 0) begin
                    log_mismatch("unexpected result", '0, seen_result);
                end else begin
                    want_result = expected_results.pop_front();
                    if (seen_result.payload_byte !== want_result.payload_byte ||
                        seen_result.byte_index   !== want_result.byte_index   ||
                        seen_result.frame_kind   !== want_result.frame_kind   ||
                        seen_result.frame_last   !== want_result.frame_last   ||
                        seen_result.frame_status !== want_result.frame_status) begin
                        log_mismatch("result mismatch", want_result, seen_result);
                    end
                end
                stall_left = rx_quiet ? 0 : $urandom_range(0, 3);
            end else if (stall_left != 0) begin
                stall_left--;
            end
            i_stall <= (stall_left != 0);
            if (i_valid && !o_stall) begin
                deframe_byte(i_rx_byte);
            end
        end
    end

    function automatic void push_byte(input logic [7:0] data);
        t_rx_item it;
        it.data = data;
        it.gap  = sender_burst ? 0 : $urandom_range(0, 3);
        rx_queue.insert(rx_queue.size(), it);
    endfunction

    // Whole frame with a correct FCS; optionally one bit flipped past the header.
    function automatic void push_frame(input logic [7:0] ftype, input logic [7:0] flen,
                                       input bit corrupt);
        logic [7:0]  body[$];
        logic [15:0] crc;
        int          pos;
        body = '{SYNC_FIRST, SYNC_SECOND, ftype, flen};
        for (int k = 0; k < int'(flen) - 6; k++) begin
            body.insert(body.size(), 8'($urandom_range(0, 255)));
        end
        crc = CRC_INIT;
        foreach (body[k]) begin
            crc = crc16_x25_step(crc, body[k]);
        end
        crc = ~crc;
        body.insert(body.size(), crc[7:0]);
        body.insert(body.size(), crc[15:8]);
        if (corrupt) begin
            pos = $urandom_range(4, body.size() - 1);
            body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        foreach (body[k]) begin
            push_byte(body[k]);
        end
    endfunction

    // One random sequence; returns the framed byte count (noise and broken sync count zero).
    function automatic int push_random_sequence();
        int         pick;
        int         sel;
        logic [7:0] ftype;
        logic [7:0] flen;
        logic [7:0] b;
        pick         = $urandom_range(0, 99);
        sel          = $urandom_range(0, 9);
        sender_burst = ($urandom_range(0, 3) == 0);
        if (sel < 4) begin
            ftype = exp_status_type;
        end else if (sel < 8) begin
            ftype = exp_encoder_type;
        end else begin
            ftype = 8'($urandom_range(0, 255));
        end
        // mostly short frames, now and then up to the longest
        flen = ($urandom_range(0, 49) == 0) ? 8'($urandom_range(6, 255))
                                            : 8'($urandom_range(6, 24));
        if (pick < 60) begin
            push_frame(ftype, flen, 1'b0);
            return int'(flen);
        end else if (pick < 70) begin
            push_frame(ftype, flen, 1'b1);
            return int'(flen);
        end else if (pick < 78) begin
            push_byte(SYNC_FIRST);
            push_byte(SYNC_SECOND);
            push_byte(ftype);
            push_byte(8'($urandom_range(0, 5)));
            return 4;
        end else if (pick < 86) begin
            push_byte(SYNC_FIRST);
            do begin
                b = 8'($urandom_range(0, 255));
            end while (b == SYNC_SECOND);
            push_byte(b);
            return 0;
        end
        for (int k = $urandom_range(1, 4); k > 0; k--) begin
            push_byte(8'($urandom_range(0, 255)));
        end
        return 0;
    endfunction

    // Config writes only while idle.
    task automatic write_frame_type(input logic idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_STATUS_TYPE) begin
            exp_status_type = val;
        end else begin
            exp_encoder_type = val;
        end
    endtask

    // Sender holds off until every queued byte is in and every result is out.
    task automatic wait_for_drain();
        do begin
            @(negedge i_clk);
        end while (rx_queue.size() != 0 || i_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [7:0] status_choice[NUM_PHASES];
        logic [7:0] encoder_choice[NUM_PHASES];
        int         counted;

        // extremes, both equal, types that look like sync bytes, two random, both 0xFF, back to reset
        status_choice  = '{8'h00, 8'hFF, 8'h80, SYNC_FIRST,  8'h00, 8'h00, 8'hFF, 8'h01};
        encoder_choice = '{8'hFF, 8'h00, 8'h80, SYNC_SECOND, 8'h00, 8'h00, 8'hFF, 8'h02};
        status_choice[4]  = 8'($urandom_range(0, 255));
        encoder_choice[4] = 8'($urandom_range(0, 255));
        status_choice[5]  = 8'($urandom_range(0, 255));
        encoder_choice[5] = 8'($urandom_range(0, 255));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, reset frame types: noise extremes, broken sync, 'M' 'M' 'C' (no lock),
        // short length with the top type, good status frame, bad CRC, zero length.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(SYNC_FIRST);
        push_byte(8'h00);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        push_byte(8'hFF);
        push_byte(8'd5);
        push_frame(8'h01, 8'd6, 1'b0);
        push_frame(8'h02, 8'd6, 1'b1);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
        push_byte(8'h07);
        push_byte(8'h00);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_for_drain();
            write_frame_type(CFG_STATUS_TYPE, status_choice[p]);
            write_frame_type(CFG_ENCODER_TYPE, encoder_choice[p]);
            @(negedge i_clk);
            rx_quiet = (p == 2);
            counted  = 0;
            if (p == 0) begin
                // longest frame: 251 payload bytes, last index 250
                sender_burst = 1'b0;
                push_frame(exp_encoder_type, 8'd255, 1'b0);
                counted = 255;
            end
            while (counted < PHASE_BYTES) begin
                counted += push_random_sequence();
            end
        end

        wait_for_drain();
        if (expected_results.size() != 0) begin
            $display("%0d results never arrived", expected_results.size());
            error_count += expected_results.size();
        end
        if (error_count == 0) begin
            $display("sync_frame_receiver_crc16 test passed");
        end else begin
            $display("sync_frame_receiver_crc16 test failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("sync_frame_receiver_crc16 test failed");
        $finish;
    end

endmodule
